### design/key_matrix_debounce_scanner_core_assert.svh
// assertion macros for the key matrix scanner checker
// expects clk and rst_n in the scope where a macro is used
`ifndef KEY_MATRIX_DEBOUNCE_SCANNER_CORE_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCE_SCANNER_CORE_ASSERT_SVH

// same-cycle implication
`define KMDS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmds assertion failed");

// next-cycle implication
`define KMDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmds assertion failed");

`endif

### design/kmds_pkg.sv
// shared types, constants and helpers of the key matrix scanner
// no dependencies
package kmds_pkg;

    localparam int MAX_ROWS      = 8;
    localparam int MAX_COLUMNS   = 16;
    localparam int HISTORY_DEPTH = 8;
    localparam int SENSE_BITS    = 8;

    // rows that can actually be sensed
    localparam int MASK_W    = (MAX_ROWS < SENSE_BITS) ? MAX_ROWS : SENSE_BITS;
    localparam int ROW_IDX_W = (MASK_W > 1) ? $clog2(MASK_W) : 1;
    localparam int ROWS_W    = $clog2(MASK_W + 1);
    localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int COLS_W    = $clog2(MAX_COLUMNS + 1);
    localparam int SLOT_W    = $clog2(HISTORY_DEPTH);

    localparam int KIND_W        = 2;
    localparam int SCANCODE_W    = 7;
    localparam int NEXT_COL_W    = 4;
    localparam int ROWS_CFG_W    = 4;
    localparam int COLS_CFG_W    = 5;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 5;
    localparam int PROD_W        = COL_W + ROWS_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROWS_USED    = 2'd0,
        CFG_COLUMNS_USED = 2'd1
    } cfg_index_t;

    // one evaluated tick waiting to be sent out
    typedef struct packed {
        logic [MASK_W-1:0]     press;
        logic [MASK_W-1:0]     rel;
        logic [SCANCODE_W-1:0] base;
        logic [NEXT_COL_W-1:0] next_col;
    } job_t;

    function automatic logic [MASK_W-1:0] row_mask(input logic [ROWS_W-1:0] rows);
        logic [MASK_W-1:0] m;
        for (int i = 0; i < MASK_W; i++)
        begin
            m[i] = (ROWS_W'(i) < rows);
        end
        return m;
    endfunction

    function automatic logic [ROW_IDX_W-1:0] lowest_index(input logic [MASK_W-1:0] v);
        logic [ROW_IDX_W-1:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = ROW_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### design/key_matrix_debounce_scanner_core.sv
// Debounced key matrix scanner, one scan tick per input item.
// In: row_sense is the sampled row lines of the column now driven, taken
//   when in_valid is high and in_stall is low.
// Out: for each tick, press items in row order, then release items in
//   row order, then one end item (kind 2, last 1) carrying next_column,
//   the column to drive for the following tick. Scancode is
//   column * rows_used + row, with rows_used capped at 8. An item is taken
//   when out_valid is high and out_stall is low.
// Config: cfg_index 0 writes rows_used, 1 writes columns_used; cfg_ready
//   is always high. Write only while no tick is in flight.
// Pipeline: a tick's input is registered, then loaded into the serializer's
//   job register, whose first item goes to the output register. A tick with
//   n events yields n + 1 output items, at most 9; the next tick is evaluated
//   in the cycle its predecessor's end item is issued, so ticks follow without
//   gaps. The event serializer sets the rate.
// Reset: all histories and key states clear, scanning starts at column 0,
//   rows_used 8 and columns_used 16. While the output is stalled the held
//   result stays and at most one more tick is held at the input.
// Depends on kmds_pkg, kmds_scan_state and kmds_event_serializer.
module key_matrix_debounce_scanner_core
    import kmds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SENSE_BITS-1:0]  row_sense,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [KIND_W-1:0]      kind,
    output logic [SCANCODE_W-1:0]  scancode,
    output logic [NEXT_COL_W-1:0]  next_column,
    output logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [ROWS_CFG_W-1:0] rows_used_reg;
    logic [COLS_CFG_W-1:0] columns_used_reg;
    logic                  in_valid_reg;
    logic [MASK_W-1:0]     sense_reg;

    logic [ROWS_W-1:0]     rows_eff;
    logic [COLS_W-1:0]     cols_eff;
    logic                  job_ready;
    logic                  take;
    job_t                  job;

    assign cfg_ready = 1'b1;
    assign take      = in_valid_reg && job_ready;
    assign in_stall  = in_valid_reg && !job_ready;

    always_comb
    begin
        rows_eff = (rows_used_reg > ROWS_CFG_W'(MASK_W)) ? ROWS_W'(MASK_W)
                                                        : ROWS_W'(rows_used_reg);
        if (columns_used_reg > COLS_CFG_W'(MAX_COLUMNS))
        begin
            cols_eff = COLS_W'(MAX_COLUMNS);
        end
        else if (columns_used_reg == '0)
        begin
            cols_eff = COLS_W'(1);
        end
        else
        begin
            cols_eff = COLS_W'(columns_used_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg    <= ROWS_CFG_W'(8);
            columns_used_reg <= COLS_CFG_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROWS_USED:    rows_used_reg    <= cfg_data[ROWS_CFG_W-1:0];
                CFG_COLUMNS_USED: columns_used_reg <= cfg_data[COLS_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            sense_reg <= row_sense[MASK_W-1:0];
        end
    end

    kmds_scan_state u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .sense    (sense_reg),
        .rows_eff (rows_eff),
        .cols_eff (cols_eff),
        .job      (job)
    );

    kmds_event_serializer u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take),
        .job_in      (job),
        .job_ready   (job_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .scancode    (scancode),
        .next_column (next_column),
        .last        (last)
    );

endmodule

### design/kmds_scan_state.sv
// per-column sample history, key state and scan position; evaluates one tick
// depends on kmds_pkg
module kmds_scan_state
    import kmds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [MASK_W-1:0] sense,
    input  logic [ROWS_W-1:0] rows_eff,
    input  logic [COLS_W-1:0] cols_eff,
    output job_t              job
);

    // all slots of one column sit in one word, read as a whole per tick
    logic [HISTORY_DEPTH-1:0][MASK_W-1:0] hist_reg [MAX_COLUMNS];
    logic [MASK_W-1:0] key_down_reg [MAX_COLUMNS];
    logic [COL_W-1:0]  col_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [MASK_W-1:0] mask;
    logic [MASK_W-1:0] sample;
    logic [MASK_W-1:0] all_high;
    logic [MASK_W-1:0] any_high;
    logic [MASK_W-1:0] kd;
    logic [MASK_W-1:0] pressed;
    logic [MASK_W-1:0] released;
    logic [COLS_W-1:0] col_plus;
    logic              wrap;
    logic [COL_W-1:0]  col_next;
    logic [SLOT_W-1:0] slot_next;
    logic [PROD_W-1:0] prod;

    always_comb
    begin
        mask     = row_mask(rows_eff);
        sample   = sense & mask;
        kd       = key_down_reg[col_reg];
        all_high = mask;
        any_high = '0;
        // the slot being written counts with its new sample
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            if (SLOT_W'(i) == slot_reg)
            begin
                all_high = all_high & sample;
                any_high = any_high | sample;
            end
            else
            begin
                all_high = all_high & hist_reg[col_reg][i];
                any_high = any_high | hist_reg[col_reg][i];
            end
        end
        pressed  = all_high & ~kd;
        released = ~any_high & kd;

        col_plus = {{(COLS_W-COL_W){1'b0}}, col_reg} + COLS_W'(1);
        wrap     = (col_plus >= cols_eff);
        col_next = wrap ? '0 : col_plus[COL_W-1:0];
        if (wrap)
        begin
            slot_next = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
        end
        else
        begin
            slot_next = slot_reg;
        end

        prod = {{ROWS_W{1'b0}}, col_reg} * {{COL_W{1'b0}}, rows_eff};

        job.press    = pressed;
        // a key beyond the row mask is cleared silently
        job.rel      = released & mask;
        job.base     = prod[SCANCODE_W-1:0];
        job.next_col = NEXT_COL_W'(col_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_COLUMNS; c++)
            begin
                key_down_reg[c] <= '0;
                hist_reg[c]     <= '0;
            end
            col_reg  <= '0;
            slot_reg <= '0;
        end
        else if (take)
        begin
            hist_reg[col_reg][slot_reg] <= sample;
            key_down_reg[col_reg]       <= (kd | pressed) & ~released;
            col_reg                     <= col_next;
            slot_reg                    <= slot_next;
        end
    end

endmodule

### design/kmds_event_serializer.sv
// holds one evaluated tick, sends events then end item, one per unstalled cycle
// depends on kmds_pkg
module kmds_event_serializer
    import kmds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  job_t                  job_in,
    output logic                  job_ready,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KIND_W-1:0]     kind,
    output logic [SCANCODE_W-1:0] scancode,
    output logic [NEXT_COL_W-1:0] next_column,
    output logic                  last
);

    job_t                  job_reg;
    logic                  job_valid_reg;
    logic                  out_valid_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [SCANCODE_W-1:0] scancode_reg;
    logic [NEXT_COL_W-1:0] next_column_reg;
    logic                  last_reg;

    logic                  out_free;
    logic                  emit;
    logic                  done;
    kind_t                 kind_sel;
    logic [MASK_W-1:0]     sel;
    logic [ROW_IDX_W-1:0]  idx;
    logic [SCANCODE_W-1:0] code;

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        emit     = job_valid_reg && out_free;
        if (job_reg.press != '0)
        begin
            kind_sel = KIND_PRESS;
            sel      = job_reg.press;
        end
        else if (job_reg.rel != '0)
        begin
            kind_sel = KIND_RELEASE;
            sel      = job_reg.rel;
        end
        else
        begin
            kind_sel = KIND_END;
            sel      = '0;
        end
        idx       = lowest_index(sel);
        code      = job_reg.base + SCANCODE_W'(idx);
        done      = emit && (kind_sel == KIND_END);
        job_ready = !job_valid_reg || done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            job_valid_reg <= 1'b1;
        end
        else if (done)
        begin
            job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job_in;
        end
        else if (emit)
        begin
            // drop the event just sent
            if (kind_sel == KIND_PRESS)
            begin
                job_reg.press <= job_reg.press & (job_reg.press - MASK_W'(1));
            end
            else if (kind_sel == KIND_RELEASE)
            begin
                job_reg.rel <= job_reg.rel & (job_reg.rel - MASK_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg        <= kind_sel;
            scancode_reg    <= (kind_sel == KIND_END) ? '0 : code;
            next_column_reg <= (kind_sel == KIND_END) ? job_reg.next_col : '0;
            last_reg        <= (kind_sel == KIND_END);
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign scancode    = scancode_reg;
    assign next_column = next_column_reg;
    assign last        = last_reg;

endmodule

### design/kmds_checker.sv
// port-level checks of the key matrix scanner, bound to the top level
// depends on kmds_pkg and key_matrix_debounce_scanner_core_assert.svh
`include "key_matrix_debounce_scanner_core_assert.svh"

module kmds_checker
    import kmds_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [KIND_W-1:0]     kind,
    input logic [SCANCODE_W-1:0] scancode,
    input logic [NEXT_COL_W-1:0] next_column,
    input logic                  last
);

    logic [KIND_W+SCANCODE_W+NEXT_COL_W:0] held;

    assign held = {kind, scancode, next_column, last};

    // last marks exactly the end item
    `KMDS_ASSERT_IMP(a_last_is_end, out_valid, last == (kind == KIND_END))

    // end item carries no scancode
    `KMDS_ASSERT_IMP(a_end_code_zero, out_valid && kind == KIND_END, scancode == '0)

    // key events carry no column
    `KMDS_ASSERT_IMP(a_event_col_zero, out_valid && kind != KIND_END, next_column == '0)

    // stalled result holds
    `KMDS_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(held))

endmodule

bind key_matrix_debounce_scanner_core kmds_checker u_kmds_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .scancode    (scancode),
    .next_column (next_column),
    .last        (last)
);

### bench/key_matrix_debounce_scanner_core_test.sv
// self-checking testbench for key_matrix_debounce_scanner_core
// predicts the press, release and end-of-tick items of each scan tick and checks them in order
// depends on kmds_pkg and the scanner core
module key_matrix_debounce_scanner_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kmds_pkg::*;

    // index with no register behind it, writes to it must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        kind_t                 kind;
        logic [SCANCODE_W-1:0] scancode;
        logic [NEXT_COL_W-1:0] next_column;
        logic                  last;
    } scan_event_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [SENSE_BITS-1:0]  row_sense = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [KIND_W-1:0]      kind;
    logic [SCANCODE_W-1:0]  scancode;
    logic [NEXT_COL_W-1:0]  next_column;
    logic                   last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // scanner state as predicted
    logic [SENSE_BITS-1:0] model_history [MAX_COLUMNS][HISTORY_DEPTH];
    logic [SENSE_BITS-1:0] model_down [MAX_COLUMNS];
    int                    model_column;
    int                    model_slot;
    logic [ROWS_CFG_W-1:0] model_rows_cfg;
    logic [COLS_CFG_W-1:0] model_cols_cfg;

    scan_event_t           expected_events [$];
    logic [SENSE_BITS-1:0] key_target [MAX_COLUMNS];

    int hold_left = 0;
    bit steady = 1'b0;
    int failures = 0;
    int ticks_sent = 0;
    int settings_written = 0;
    int presses_seen = 0;
    int releases_seen = 0;
    int ends_seen = 0;

    key_matrix_debounce_scanner_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .row_sense   (row_sense),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .scancode    (scancode),
        .next_column (next_column),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic predict_scan_tick(input logic [SENSE_BITS-1:0] sense);
        int rows;
        int cols;
        int s;
        int i;
        logic [SENSE_BITS-1:0] mask;
        logic [SENSE_BITS-1:0] all_high;
        logic [SENSE_BITS-1:0] any_high;
        logic [SENSE_BITS-1:0] pressed;
        logic [SENSE_BITS-1:0] released;
        scan_event_t ev;
        rows = (model_rows_cfg > MASK_W) ? MASK_W : int'(model_rows_cfg);
        cols = (model_cols_cfg > MAX_COLUMNS) ? MAX_COLUMNS : int'(model_cols_cfg);
        if (cols == 0)
        begin
            cols = 1;
        end
        mask = SENSE_BITS'((1 << rows) - 1);
        model_history[model_column][model_slot] = sense & mask;
        all_high = mask;
        any_high = '0;
        for (s = 0; s < HISTORY_DEPTH; s++)
        begin
            all_high &= model_history[model_column][s];
            any_high |= model_history[model_column][s];
        end
        pressed = all_high & ~model_down[model_column];
        released = ~any_high & model_down[model_column];
        ev.next_column = '0;
        ev.last = 1'b0;
        ev.kind = KIND_PRESS;
        for (i = 0; i < rows; i++)
        begin
            if (pressed[i])
            begin
                ev.scancode = SCANCODE_W'(model_column * rows + i);
                expected_events.push_back(ev);
            end
        end
        ev.kind = KIND_RELEASE;
        for (i = 0; i < rows; i++)
        begin
            if (released[i])
            begin
                ev.scancode = SCANCODE_W'(model_column * rows + i);
                expected_events.push_back(ev);
            end
        end
        // keys beyond the row mask can still drop silently
        model_down[model_column] = (model_down[model_column] | pressed) & ~released;
        model_column++;
        if (model_column >= cols)
        begin
            model_column = 0;
            model_slot = (model_slot + 1) % HISTORY_DEPTH;
        end
        ev.kind = KIND_END;
        ev.scancode = '0;
        ev.next_column = NEXT_COL_W'(model_column);
        ev.last = 1'b1;
        expected_events.push_back(ev);
    endtask

    task automatic send_scan(input logic [SENSE_BITS-1:0] sense);
        int gap;
        int r;
        gap = 0;
        if (!steady)
        begin
            r = $urandom_range(0, 19);
            if (r >= 18)
            begin
                gap = $urandom_range(8, 30);
            end
            else if (r >= 12)
            begin
                gap = $urandom_range(1, 3);
            end
        end
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        row_sense <= sense;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_scan_tick(sense);
        ticks_sent++;
    endtask

    task automatic wait_idle(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_idle(6);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (index)
            CFG_ROWS_USED:    model_rows_cfg = data[ROWS_CFG_W-1:0];
            CFG_COLUMNS_USED: model_cols_cfg = data[COLS_CFG_W-1:0];
            default:          ;
        endcase
        settings_written++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_scan(8'hFF);
        send_scan(8'h00);
        send_scan(8'hA5);
    endtask

    // column index is past the new count, so it is scanned once more before wrapping
    task automatic test_column_shrink();
        write_register(CFG_COLUMNS_USED, 5'd1);
        write_register(CFG_ROWS_USED, 5'd15);
        repeat (8) send_scan(8'hFF);
    endtask

    // upper sense bits are ignored and keys above the mask drop without an item
    task automatic test_row_shrink();
        write_register(CFG_ROWS_USED, 5'd2);
        repeat (8) send_scan(8'hFC);
    endtask

    task automatic test_config_edges();
        write_register(CFG_ROWS_USED, 5'd0);
        write_register(CFG_COLUMNS_USED, 5'd0);
        write_register(CFG_UNUSED_INDEX, 5'd1);
        repeat (3) send_scan(8'hFF);
    endtask

    task automatic run_phase(input int count, input int churn, input bit pressure);
        int k;
        int c;
        logic [SENSE_BITS-1:0] sense;
        for (k = 0; k < count; k++)
        begin
            if (pressure && k == 60)
            begin
                wait_idle(0);
            end
            if (pressure && k == 120)
            begin
                hold_left = 300;
            end
            if (model_column == 0)
            begin
                for (c = 0; c < MAX_COLUMNS; c++)
                begin
                    if ($urandom_range(1, churn) == 1)
                    begin
                        key_target[c] = SENSE_BITS'($urandom);
                    end
                end
            end
            sense = key_target[model_column];
            case ($urandom_range(0, 15))
                0:       sense = SENSE_BITS'($urandom);
                1:       sense ^= SENSE_BITS'(1 << $urandom_range(0, SENSE_BITS - 1));
                default: ;
            endcase
            send_scan(sense);
        end
    endtask

    task automatic test_random_sweeps();
        int start_ticks;
        int eff_cols;
        int len;
        int c;
        logic [CFG_DATA_W-1:0] rows_val;
        logic [CFG_DATA_W-1:0] cols_val;
        start_ticks = ticks_sent;
        // full width so every column debounces and scancodes reach the top
        write_register(CFG_ROWS_USED, 5'd8);
        write_register(CFG_COLUMNS_USED, 5'd31);
        for (c = 0; c < MAX_COLUMNS; c++)
        begin
            key_target[c] = SENSE_BITS'($urandom);
        end
        key_target[MAX_COLUMNS-1] = '1;
        run_phase(136, 60, 1'b1);
        while (ticks_sent - start_ticks < 320)
        begin
            case ($urandom_range(0, 9))
                0:       rows_val = 5'd0;
                1:       rows_val = 5'd1;
                2:       rows_val = 5'd8;
                3:       rows_val = 5'd15;
                4:       rows_val = CFG_DATA_W'($urandom_range(0, 31));
                default: rows_val = CFG_DATA_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       cols_val = 5'd0;
                1:       cols_val = 5'd31;
                2:       cols_val = 5'd16;
                default: cols_val = CFG_DATA_W'($urandom_range(1, 4));
            endcase
            write_register(CFG_ROWS_USED, rows_val);
            write_register(CFG_COLUMNS_USED, cols_val);
            steady = ($urandom_range(0, 3) == 0);
            eff_cols = (cols_val > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_val);
            if (eff_cols == 0)
            begin
                eff_cols = 1;
            end
            len = eff_cols * HISTORY_DEPTH * $urandom_range(2, 3);
            if (len > 64)
            begin
                len = 64;
            end
            run_phase(len, 8, 1'b0);
        end
        steady = 1'b0;
    endtask

    // receiver: random stall runs, or a long hold-off when one is requested
    initial
    begin : receiver
        int run;
        bit stalling;
        run = 0;
        stalling = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (steady)
                begin
                    stalling = 1'b0;
                    run = 1;
                end
                else if (run == 0)
                begin
                    stalling = !stalling;
                    if (stalling)
                    begin
                        run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                          : $urandom_range(1, 3);
                    end
                    else
                    begin
                        run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 8);
                    end
                end
                run--;
                out_stall <= stalling;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        scan_event_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_events.size() == 0)
            begin
                failures++;
                $display("%0t ns: unexpected item, expected none, got kind %0d scancode %0d",
                         $time, kind, scancode);
            end
            else
            begin
                want = expected_events.pop_front();
                if (kind !== want.kind || scancode !== want.scancode ||
                    next_column !== want.next_column || last !== want.last)
                begin
                    failures++;
                    $display("%0t ns: mismatch, expected kind %0d scancode %0d next %0d last %0d",
                             $time, want.kind, want.scancode, want.next_column, want.last);
                    $display("%0t ns:           actual kind %0d scancode %0d next %0d last %0d",
                             $time, kind, scancode, next_column, last);
                end
                case (want.kind)
                    KIND_PRESS:   presses_seen++;
                    KIND_RELEASE: releases_seen++;
                    default:      ends_seen++;
                endcase
            end
        end
    end

    initial
    begin : main
        int c;
        int s;
        for (c = 0; c < MAX_COLUMNS; c++)
        begin
            model_down[c] = '0;
            key_target[c] = '0;
            for (s = 0; s < HISTORY_DEPTH; s++)
            begin
                model_history[c][s] = '0;
            end
        end
        model_column = 0;
        model_slot = 0;
        model_rows_cfg = ROWS_CFG_W'(MAX_ROWS);
        model_cols_cfg = COLS_CFG_W'(MAX_COLUMNS);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_column_shrink();
        test_row_shrink();
        test_config_edges();
        test_random_sweeps();

        wait_idle(20);
        $display("ran %0d scan ticks across %0d register writes", ticks_sent, settings_written);
        $display("checked %0d press, %0d release and %0d end-of-tick items",
                 presses_seen, releases_seen, ends_seen);
        if (failures == 0)
        begin
            $display("key_matrix_debounce_scanner_core_test passed");
        end
        else
        begin
            $display("key_matrix_debounce_scanner_core_test failed");
        end
        $finish;
    end

    // generous bound on the whole run
    initial
    begin : watchdog
        #10_000_000;
        $display("timeout with %0d items still expected", expected_events.size());
        $display("key_matrix_debounce_scanner_core_test failed");
        $finish;
    end

endmodule
